### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; every other file of the block refers to it by scoped names.
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ATTR = 1'b0;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  // Operations.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_BACK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CHAR_W-1:0] char_code;
    logic [4:0]        read_row;
    logic [6:0]        read_col;
  } in_word_t;

  typedef struct packed {
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;
    logic [10:0]       cursor_pos;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } out_word_t;

endpackage

### hw/rtl/tcw_in_if.sv
// Command channel of the text console writer: valid, ready and one command word.
// Depends on tcw_pkg for the word type.
interface tcw_in_if;
  logic              valid;
  logic              ready;
  tcw_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/tcw_out_if.sv
// Response channel of the text console writer: valid, ready and one result word.
// Depends on tcw_pkg for the word type.
interface tcw_out_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/text_console_writer.sv
// Text console writer top level: configuration register port, sequencer and cell store.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_cell_mem and tcw_ctrl.

// The block keeps a ROWS x COLUMNS screen of 16-bit cells in one single-port RAM
// and takes one command word at a time. A put, carriage return, line feed, tab or
// backspace that does not scroll loads the response register in the execute state
// when that register is free, and the next command word can be accepted once the
// block is back in idle. A cell read loads the response in the finish state, as the
// RAM read is registered. A scroll blanks the new bottom row cell by cell and then
// loads the response in the finish state. Rows are kept at a rotating offset, so
// no row is copied. A clear rewrites every cell, one cell written per cycle.
// After reset the block fills all ROWS*COLUMNS cells (2000 at 80x25) of the store
// with blank cells and accepts no command word meanwhile; attribute writes are taken
// at any time. The response register lets the next command enter while a response
// still waits to be taken; a response that is held up that long stalls the block.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  tcw_in_if.sink                     cmd,
  tcw_out_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::APB_AW-1:0] paddr,
  input  logic [tcw_pkg::APB_DW-1:0] pwdata,
  output logic [tcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic [tcw_pkg::ATTR_W-1:0] attr;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == tcw_pkg::REG_ATTR) begin
      attr <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_ATTR) ?
                  tcw_pkg::APB_DW'(attr) : '0;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .cmd       (cmd),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  tcw_cell_mem #(
    .DEPTH (CELLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Only one command word is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in work");

  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.scrolled) |->
      (rsp.payload.cursor_row == 5'(ROWS - 1) && rsp.payload.cursor_col == 7'd0))
    else $error("scroll reported with cursor off the bottom row start");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.payload.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

endmodule

### hw/rtl/tcw_cell_mem.sv
// Screen cell store: single-port synchronous RAM with a registered read.
// Depends on tcw_pkg for the cell width.
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [AW-1:0]             addr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[addr];
    end
  end

endmodule

### hw/rtl/tcw_ctrl.sv
// Sequencer of the text console writer: cursor, row offset, cell address,
// fill sweeps and the response register. Depends on tcw_pkg and the channel interfaces.
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  localparam int CELLS = ROWS * COLUMNS,
  localparam int AW    = $clog2(CELLS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tcw_pkg::ATTR_W-1:0] attr,
  tcw_in_if.sink                     cmd,
  tcw_out_if.source                  rsp,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_addr,
  output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]    state;
  logic [AW-1:0] sweep;
  logic [CW-1:0] scol;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] base;
  logic          scrl;
  logic          out_valid;
  tcw_pkg::out_word_t out_word;

  // Captured command word.
  logic [1:0]                 op;
  logic [tcw_pkg::CHAR_W-1:0] ch;
  logic [RW-1:0]              rd_row;
  logic [CW-1:0]              rd_col;
  logic                       rd_ok;

  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic [CW:0]   col_inc;
  logic [CW:0]   col_p4;
  logic [CW:0]   col_tab;
  logic          at_bottom;
  logic          line_feed;
  logic          need_scroll;
  logic          wr;
  logic          rd;
  logic [CW-1:0] wr_col;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic [RW-1:0] lrow;
  logic [CW-1:0] acol;
  logic [RW:0]   psum;
  logic [RW-1:0] phys;
  logic [AW-1:0] cell_addr;
  logic          out_free;
  logic          load_out;

  assign col_inc   = {1'b0, cur_col} + (CW+1)'(1);
  assign col_p4    = {1'b0, cur_col} + (CW+1)'(4);
  assign col_tab   = {col_p4[CW:2], 2'b00};
  assign at_bottom = (cur_row == RW'(ROWS - 1));

  always_comb begin
    row_next  = cur_row;
    col_next  = cur_col;
    line_feed = 1'b0;
    wr        = 1'b0;
    rd        = 1'b0;
    wr_col    = cur_col;
    wr_data   = {attr, tcw_pkg::CH_BLANK};
    if (state == S_EXEC) begin
      unique case (op)
        tcw_pkg::OP_PUT: begin
          priority if (ch == tcw_pkg::CH_CR) begin
            col_next = '0;
          end else if (ch == tcw_pkg::CH_LF) begin
            line_feed = 1'b1;
          end else if (ch == tcw_pkg::CH_TAB) begin
            if (col_tab >= (CW+1)'(COLUMNS)) begin
              line_feed = 1'b1;
            end else begin
              col_next = CW'(col_tab);
            end
          end else begin
            wr      = 1'b1;
            wr_data = {attr, ch};
            if (col_inc >= (CW+1)'(COLUMNS)) begin
              line_feed = 1'b1;
            end else begin
              col_next = CW'(col_inc);
            end
          end
        end
        tcw_pkg::OP_BACK: begin
          if (cur_col != '0) begin
            col_next = cur_col - CW'(1);
            wr_col   = cur_col - CW'(1);
            wr       = 1'b1;
          end
        end
        tcw_pkg::OP_READ: begin
          rd = rd_ok;
        end
        tcw_pkg::OP_CLEAR: begin
          row_next = '0;
          col_next = '0;
        end
        default: begin
          row_next = cur_row;
        end
      endcase
      if (line_feed) begin
        col_next = '0;
        if (!at_bottom) begin
          row_next = cur_row + RW'(1);
        end
      end
    end
  end

  assign need_scroll = line_feed && at_bottom;

  // Logical rows sit at a rotating offset in the store, so a scroll only
  // blanks the old top row, which becomes the new bottom row.
  always_comb begin
    if (state == S_SCROLL) begin
      lrow = '0;
      acol = scol;
    end else if (op == tcw_pkg::OP_READ) begin
      lrow = rd_row;
      acol = rd_col;
    end else begin
      lrow = cur_row;
      acol = wr_col;
    end
  end

  assign psum      = {1'b0, lrow} + {1'b0, base};
  assign phys      = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : RW'(psum);
  assign cell_addr = AW'(32'(phys) * COLUMNS + 32'(acol));

  assign mem_we = (state == S_EXEC && wr) || state == S_SCROLL ||
                  state == S_CLEAR || state == S_INIT;
  assign mem_re = (state == S_EXEC) && rd;
  assign mem_addr = (state == S_CLEAR || state == S_INIT) ? sweep : cell_addr;
  assign mem_wdata = (state == S_INIT) ? tcw_pkg::RESET_CELL : wr_data;

  assign out_free  = !out_valid || rsp.ready;
  assign load_out  = out_free &&
                     ((state == S_FINISH) ||
                      (state == S_EXEC && !need_scroll &&
                       op != tcw_pkg::OP_READ && op != tcw_pkg::OP_CLEAR));
  assign cmd.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      scol      <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      base      <= '0;
      scrl      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_row <= row_next;
          cur_col <= col_next;
          scrl    <= need_scroll;
          priority if (op == tcw_pkg::OP_CLEAR) begin
            base  <= '0;
            state <= S_CLEAR;
          end else if (need_scroll) begin
            scol  <= '0;
            state <= S_SCROLL;
          end else if (load_out) begin
            state <= S_IDLE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCROLL: begin
          scol <= scol + CW'(1);
          if (scol == CW'(COLUMNS - 1)) begin
            base  <= (base == RW'(ROWS - 1)) ? '0 : base + RW'(1);
            state <= S_FINISH;
          end
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) begin
            sweep <= '0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op     <= cmd.payload.operation;
      ch     <= cmd.payload.char_code;
      rd_row <= RW'(cmd.payload.read_row);
      rd_col <= CW'(cmd.payload.read_col);
      rd_ok  <= (32'(cmd.payload.read_row) < ROWS) && (32'(cmd.payload.read_col) < COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.cursor_row <= 5'(row_next);
      out_word.cursor_col <= 7'(col_next);
      out_word.cursor_pos <= 11'(32'(row_next) * COLUMNS + 32'(col_next));
      out_word.cell_value <= (state == S_FINISH && op == tcw_pkg::OP_READ && rd_ok) ?
                             mem_rdata : '0;
      out_word.scrolled   <= (state == S_FINISH) && scrl;
    end
  end

endmodule
